[rtl/core/swpc_pkg.sv]
// shared types and constants for the sliding window peak event counter
// no dependencies

package swpc_pkg;

  localparam int STAMP_W   = 32;
  localparam int WIN_W     = 31;
  localparam int CNT_OUT_W = 11;
  localparam int OUT_W     = 88;

  localparam logic [WIN_W-1:0] WIN_RESET = 31'd60;

  typedef logic [WIN_W-1:0] win_t;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  typedef logic state_t;

endpackage

[rtl/core/swpc_ram.sv]
// timestamp store of the sliding window peak event counter
// one write and one registered read port, write-first on equal address; uses no package

module swpc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/swpc_span.sv]
// span compare unit of the sliding window peak event counter
// depends on swpc_pkg for the window type

module swpc_span #(
  parameter int TB = 32
) (
  input  logic [TB-1:0]    newest,
  input  logic [TB-1:0]    oldest,
  input  swpc_pkg::win_t   window,
  output logic             exceeds
);

  localparam int SW = (TB > swpc_pkg::WIN_W) ? TB : swpc_pkg::WIN_W;

  logic [TB-1:0] span;

  always_comb begin
    span    = (newest >= oldest) ? (newest - oldest) : '0;
    exceeds = SW'(span) > SW'(window);
  end

endmodule

[rtl/core/sliding_window_peak_event_count.sv]
// top level of the sliding window peak event counter
// depends on swpc_pkg, swpc_ram and swpc_span
//
// usage:
//   in_*  : one event timestamp per request, in_tdata[31:0] = event_time
//   out_* : one result per request; the output register holds it until taken
//   cfg_* : window_seconds, written whenever cfg_wr_en is high, reset value 60
// each accepted timestamp is pushed into a FIFO_DEPTH entry ring; when the
// ring is full the oldest entry is dropped first and overflow is set
// the sequencer then reads the oldest entry once per cycle and drops it while
// newest minus oldest is above the window and more than one entry remains,
// using one shared span compare; the scan state then writes the result into
// the output register once eviction has stopped and that register is free
// a new timestamp is taken only after the previous one has left the scan state;
// the eviction loop walks the ring through the single ram read port
// in_tready is high only while the sequencer is idle; if the receiver stalls,
// the finished result waits and the next item halts at its last step until
// the output register is free
// reset clears pointers, counts and the peak; ring contents need no clearing

module sliding_window_peak_event_count #(
  parameter int FIFO_DEPTH = 1024,
  parameter int TIME_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // event_time[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // window_count[10:0], peak_count[21:11],
                                  // peak_start[53:22], peak_end[85:54],
                                  // overflow[86], zero[87]
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(FIFO_DEPTH);
  localparam logic [CW-1:0] ONE_CNT   = CW'(1);

  swpc_pkg::state_t state_r, state_nxt;
  swpc_pkg::win_t   window_r;
  logic [AW-1:0]    oldest_r, oldest_nxt;
  logic [AW-1:0]    newest_r, newest_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    peak_r, peak_nxt;
  logic [TIME_BITS-1:0] peak_first_r, peak_first_nxt;
  logic [TIME_BITS-1:0] peak_last_r, peak_last_nxt;
  logic [TIME_BITS-1:0] newest_t_r, newest_t_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [swpc_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic                 in_fire;
  logic                 out_free;
  logic                 wr_en;
  logic [TIME_BITS-1:0] in_time;
  logic [TIME_BITS-1:0] oldest_t;
  logic                 exceeds;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  assign in_tready = (state_r == swpc_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_time   = TIME_BITS'(in_tdata);
  assign wr_en     = in_fire;

  swpc_ram #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (TIME_BITS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (newest_r),
    .wr_data (in_time),
    .rd_addr (oldest_nxt),
    .rd_data (oldest_t)
  );

  swpc_span #(
    .TB (TIME_BITS)
  ) u_span (
    .newest  (newest_t_r),
    .oldest  (oldest_t),
    .window  (window_r),
    .exceeds (exceeds)
  );

  always_comb begin
    state_nxt      = state_r;
    oldest_nxt     = oldest_r;
    newest_nxt     = newest_r;
    count_nxt      = count_r;
    peak_nxt       = peak_r;
    peak_first_nxt = peak_first_r;
    peak_last_nxt  = peak_last_r;
    newest_t_nxt   = newest_t_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    case (state_r)
      swpc_pkg::ST_IDLE: begin
        if (in_fire) begin
          newest_t_nxt = in_time;
          newest_nxt   = next_slot(newest_r);
          if (count_r >= FULL_CNT) begin
            oldest_nxt = next_slot(oldest_r);
            ovf_nxt    = 1'b1;
          end else begin
            count_nxt  = count_r + ONE_CNT;
            ovf_nxt    = 1'b0;
          end
          state_nxt = swpc_pkg::ST_SCAN;
        end
      end
      swpc_pkg::ST_SCAN: begin
        if (exceeds && (count_r > ONE_CNT)) begin
          oldest_nxt = next_slot(oldest_r);
          count_nxt  = count_r - ONE_CNT;
        end else if (out_free) begin
          if (count_r > peak_r) begin
            peak_nxt       = count_r;
            peak_first_nxt = oldest_t;
            peak_last_nxt  = newest_t_r;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, ovf_r,
                           swpc_pkg::STAMP_W'(peak_last_nxt),
                           swpc_pkg::STAMP_W'(peak_first_nxt),
                           swpc_pkg::CNT_OUT_W'(peak_nxt),
                           swpc_pkg::CNT_OUT_W'(count_r)};
          state_nxt = swpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= swpc_pkg::ST_IDLE;
      window_r     <= swpc_pkg::WIN_RESET;
      oldest_r     <= '0;
      newest_r     <= '0;
      count_r      <= '0;
      peak_r       <= '0;
      peak_first_r <= '0;
      peak_last_r  <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      oldest_r     <= oldest_nxt;
      newest_r     <= newest_nxt;
      count_r      <= count_nxt;
      peak_r       <= peak_nxt;
      peak_first_r <= peak_first_nxt;
      peak_last_r  <= peak_last_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    newest_t_r <= newest_t_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above ring depth");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == swpc_pkg::ST_SCAN)
    else $error("accepted request did not start a scan");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == swpc_pkg::ST_SCAN |-> count_r != '0)
    else $error("scan with empty window");

  a_peak_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == swpc_pkg::ST_IDLE |-> peak_r >= count_r)
    else $error("peak below current window count");

endmodule
